FILE: sv/csched_pkg.sv
// Shared types and constants for the cooperative task scheduler.
package csched_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RESULT_CAP = 8;
  localparam int CNT_W      = $clog2(RESULT_CAP);

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_ADD      = 2'd1,
    OP_DEL      = 2'd2,
    OP_DISPATCH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_TICK_DONE = 3'd0,
    KIND_ADDED     = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_DELETED   = 3'd3,
    KIND_IGNORED   = 3'd4,
    KIND_RUN       = 3'd5,
    KIND_NONE      = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_ACTIVE  = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_TICK,
    FSM_DISP
  } fsm_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  task_handle;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
    logic [2:0]  target_slot;
  } in_req_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot_index;
    logic [7:0] run_handle;
    logic       last;
  } out_res_t;

  typedef struct packed {
    logic              load;
    logic              exec;
    logic              tick_slot;
    logic              run_slot;
    logic              emit;
    kind_t             kind;
    logic              last;
    logic [SLOT_W-1:0] idx;
  } csched_cmd_t;

  typedef struct packed {
    logic slot_empty;
    logic slot_ready;
    logic more_ready;
  } csched_sts_t;

endpackage

FILE: sv/csched_datapath.sv
// Slot table, request register and result register of the scheduler.
module csched_datapath import csched_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  in_req_t     in_req,
  input  csched_cmd_t cmd,
  output csched_sts_t sts,
  output logic        out_valid,
  output out_res_t    out_res
);

  slot_st_t          st_r    [NUM_SLOTS];
  logic [7:0]        hnd_r   [NUM_SLOTS];
  logic [15:0]       dly_r   [NUM_SLOTS];
  logic [15:0]       per_r   [NUM_SLOTS];
  logic [7:0]        runs_r  [NUM_SLOTS];
  in_req_t           req_r;
  logic              out_valid_r;
  out_res_t          out_res_r;
  out_res_t          out_nxt;

  logic [NUM_SLOTS-1:0] ready_vec;
  logic [NUM_SLOTS-1:0] walk_vec;
  logic [NUM_SLOTS-1:0] after_vec;
  logic                 add_found;
  logic [SLOT_W-1:0]    add_slot;
  logic [SLOT_W-1:0]    tgt_slot;
  logic                 del_ok;
  logic                 is_add;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ready_vec[i] = (st_r[i] == SLOT_ACTIVE) && (runs_r[i] != 8'd0);
      after_vec[i] = (i > int'(cmd.idx));
    end
    walk_vec[0] = (st_r[0] != SLOT_EMPTY);
    for (int i = 1; i < NUM_SLOTS; i++) begin
      walk_vec[i] = walk_vec[i-1] && (st_r[i] != SLOT_EMPTY);
    end
  end

  assign sts.slot_empty = (st_r[cmd.idx] == SLOT_EMPTY);
  assign sts.slot_ready = ready_vec[cmd.idx];
  assign sts.more_ready = |(ready_vec & walk_vec & after_vec);

  always_comb begin
    add_found = 1'b0;
    add_slot  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (st_r[i] != SLOT_ACTIVE) begin
        add_found = 1'b1;
        add_slot  = SLOT_W'(i);
      end
    end
  end

  assign is_add   = (req_r.opcode == OP_ADD);
  assign tgt_slot = SLOT_W'(req_r.target_slot);
  assign del_ok   = (int'(req_r.target_slot) < NUM_SLOTS) && (st_r[tgt_slot] == SLOT_ACTIVE);

  always_comb begin
    out_nxt.kind       = cmd.kind;
    out_nxt.slot_index = 3'd0;
    out_nxt.run_handle = 8'd0;
    out_nxt.last       = cmd.last;
    if (cmd.exec) begin
      out_nxt.last = 1'b1;
      if (is_add) begin
        out_nxt.kind       = add_found ? KIND_ADDED : KIND_FULL;
        out_nxt.slot_index = add_found ? 3'(add_slot) : 3'd0;
      end else begin
        out_nxt.kind       = del_ok ? KIND_DELETED : KIND_IGNORED;
        out_nxt.slot_index = req_r.target_slot;
      end
    end else if (cmd.run_slot) begin
      out_nxt.slot_index = 3'(cmd.idx);
      out_nxt.run_handle = hnd_r[cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        st_r[i] <= SLOT_EMPTY;
      end
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit || cmd.exec;
      if (cmd.exec && is_add && add_found) begin
        st_r[add_slot] <= SLOT_ACTIVE;
      end
      if (cmd.exec && !is_add && del_ok) begin
        st_r[tgt_slot] <= SLOT_DELETED;
      end
      if (cmd.run_slot && (per_r[cmd.idx] == 16'd0)) begin
        st_r[cmd.idx] <= SLOT_DELETED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.exec && is_add && add_found) begin
      hnd_r[add_slot]  <= req_r.task_handle;
      dly_r[add_slot]  <= req_r.first_delay;
      per_r[add_slot]  <= req_r.repeat_period;
      runs_r[add_slot] <= 8'd0;
    end
    if (cmd.tick_slot && (st_r[cmd.idx] == SLOT_ACTIVE)) begin
      if (dly_r[cmd.idx] != 16'd0) begin
        dly_r[cmd.idx] <= dly_r[cmd.idx] - 16'd1;
      end else begin
        dly_r[cmd.idx] <= per_r[cmd.idx];
        if (runs_r[cmd.idx] != 8'hFF) begin
          runs_r[cmd.idx] <= runs_r[cmd.idx] + 8'd1;
        end
      end
    end
    if (cmd.run_slot) begin
      runs_r[cmd.idx] <= runs_r[cmd.idx] - 8'd1;
    end
    if (cmd.emit || cmd.exec) begin
      out_res_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: sv/csched_ctrl.sv
// Controller state machine that sequences requests over the slot table.
module csched_ctrl import csched_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [1:0]  in_opcode,
  input  csched_sts_t sts,
  output logic        busy,
  output csched_cmd_t cmd
);

  fsm_t              state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              accept;
  logic              idx_last;
  logic              run_here;
  logic              run_last;
  logic              walk_end;

  assign accept   = start && (state_r == FSM_IDLE);
  assign idx_last = (idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign run_here = !sts.slot_empty && sts.slot_ready;
  assign run_last = (n_r == CNT_W'(RESULT_CAP - 1)) || !sts.more_ready;
  assign walk_end = sts.slot_empty || idx_last;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    case (state_r)
      FSM_IDLE: begin
        idx_nxt = '0;
        n_nxt   = '0;
        if (accept) begin
          case (in_opcode)
            OP_TICK:     state_nxt = FSM_TICK;
            OP_DISPATCH: state_nxt = FSM_DISP;
            default:     state_nxt = FSM_EXEC;
          endcase
        end
      end
      FSM_EXEC: state_nxt = FSM_IDLE;
      FSM_TICK: begin
        if (walk_end) begin
          state_nxt = FSM_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      FSM_DISP: begin
        if (run_here) begin
          n_nxt = n_r + 1'b1;
        end
        if ((run_here && run_last) || (!run_here && walk_end)) begin
          state_nxt = FSM_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = KIND_TICK_DONE;
    cmd.idx  = idx_r;
    busy     = (state_r != FSM_IDLE);
    case (state_r)
      FSM_IDLE: cmd.load = accept;
      FSM_EXEC: cmd.exec = 1'b1;
      FSM_TICK: begin
        cmd.tick_slot = !sts.slot_empty;
        if (walk_end) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_TICK_DONE;
          cmd.last = 1'b1;
        end
      end
      FSM_DISP: begin
        if (run_here) begin
          cmd.run_slot = 1'b1;
          cmd.emit     = 1'b1;
          cmd.kind     = KIND_RUN;
          cmd.last     = run_last;
        end else if (walk_end) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_NONE;
          cmd.last = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
      idx_r   <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
    end
  end

endmodule

FILE: sv/cooperative_task_scheduler_core.sv
// Top level of the cooperative task scheduler: controller plus slot datapath.
//
//   Channel   Ports                     Transfer
//   request   start, busy, in_req       taken when start is high and busy is low
//   result    out_valid, out_res        one cycle per result, cannot be held off
//
// Add and delete execute in the cycle after acceptance and strobe their result in the
// cycle after that, during which the next request can be taken. Tick and dispatch visit
// one slot per cycle, and dispatch marks its final result with last. Reset is synchronous
// and active low; it empties every slot. The receiver cannot stall results; a request
// waits only while busy is high.
module cooperative_task_scheduler_core import csched_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  csched_cmd_t cmd;
  csched_sts_t sts;

  csched_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_req.opcode),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  csched_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("Result appeared without the block being busy.");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("Result appeared right after a request was accepted.");

  a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy == !out_res.last))
    else $error("Busy does not match the last flag of a result.");

  a_only_runs_continue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last) |-> (out_res.kind == KIND_RUN))
    else $error("A result other than a run was not marked last.");

endmodule

FILE: test/cooperative_task_scheduler_core_tb.sv
// Self-checking testbench for the cooperative task scheduler core.
module cooperative_task_scheduler_core_tb;
  import csched_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_req_t  in_req = '0;
  logic     out_valid;
  out_res_t out_res;

  in_req_t  pending_requests[$];
  out_res_t expected_results[$];
  int       mismatch_count = 0;
  int       issued_count = 0;

  slot_st_t    slot_state[NUM_SLOTS];
  logic [7:0]  slot_handle[NUM_SLOTS];
  logic [15:0] slot_delay[NUM_SLOTS];
  logic [15:0] slot_period[NUM_SLOTS];
  logic [7:0]  slot_runs[NUM_SLOTS];

  cooperative_task_scheduler_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic queue_request(input op_t op, input logic [7:0] handle,
                               input logic [15:0] delay, input logic [15:0] period,
                               input logic [2:0] slot);
    in_req_t r;
    r.opcode        = op;
    r.task_handle   = handle;
    r.first_delay   = delay;
    r.repeat_period = period;
    r.target_slot   = slot;
    pending_requests.push_back(r);
  endtask

  function automatic out_res_t make_result(input kind_t kind, input int slot,
                                           input logic [7:0] handle, input logic last);
    out_res_t res;
    res.kind       = kind;
    res.slot_index = slot[2:0];
    res.run_handle = handle;
    res.last       = last;
    return res;
  endfunction

  task automatic free_slot(input int s);
    slot_handle[s] = '0;
    slot_delay[s]  = '0;
    slot_period[s] = '0;
    slot_runs[s]   = '0;
    slot_state[s]  = SLOT_DELETED;
  endtask

  task automatic predict_request(input in_req_t r);
    out_res_t run_list[$];
    int       s;
    int       t;
    bit       placed;
    case (op_t'(r.opcode))
      OP_TICK: begin
        for (s = 0; s < NUM_SLOTS && slot_state[s] != SLOT_EMPTY; s++) begin
          if (slot_state[s] == SLOT_ACTIVE) begin
            if (slot_delay[s] != 0) begin
              slot_delay[s] = slot_delay[s] - 16'd1;
            end else begin
              slot_delay[s] = slot_period[s];
              if (slot_runs[s] != 8'd255) slot_runs[s] = slot_runs[s] + 8'd1;
            end
          end
        end
        expected_results.push_back(make_result(KIND_TICK_DONE, 0, 8'd0, 1'b1));
      end
      OP_ADD: begin
        placed = 1'b0;
        for (s = 0; s < NUM_SLOTS && !placed; s++) begin
          if (slot_state[s] != SLOT_ACTIVE) begin
            slot_handle[s] = r.task_handle;
            slot_delay[s]  = r.first_delay;
            slot_period[s] = r.repeat_period;
            slot_runs[s]   = '0;
            slot_state[s]  = SLOT_ACTIVE;
            placed = 1'b1;
            expected_results.push_back(make_result(KIND_ADDED, s, 8'd0, 1'b1));
          end
        end
        if (!placed) expected_results.push_back(make_result(KIND_FULL, 0, 8'd0, 1'b1));
      end
      OP_DEL: begin
        t = r.target_slot;
        if (t < NUM_SLOTS && slot_state[t] == SLOT_ACTIVE) begin
          free_slot(t);
          expected_results.push_back(make_result(KIND_DELETED, t, 8'd0, 1'b1));
        end else begin
          expected_results.push_back(make_result(KIND_IGNORED, t, 8'd0, 1'b1));
        end
      end
      default: begin
        for (s = 0; s < NUM_SLOTS && slot_state[s] != SLOT_EMPTY &&
             run_list.size() < RESULT_CAP; s++) begin
          if (slot_state[s] == SLOT_ACTIVE && slot_runs[s] != 0) begin
            slot_runs[s] = slot_runs[s] - 8'd1;
            run_list.push_back(make_result(KIND_RUN, s, slot_handle[s], 1'b0));
            if (slot_period[s] == 0) free_slot(s);
          end
        end
        if (run_list.size() == 0) begin
          expected_results.push_back(make_result(KIND_NONE, 0, 8'd0, 1'b1));
        end else begin
          run_list[run_list.size()-1].last = 1'b1;
          foreach (run_list[i]) expected_results.push_back(run_list[i]);
        end
      end
    endcase
  endtask

  task automatic queue_random_request();
    logic [7:0]  handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic [2:0]  slot;
    int          pick;
    handle = 8'($urandom);
    delay  = 16'($urandom);
    period = 16'($urandom);
    slot   = 3'($urandom);
    pick   = $urandom_range(0, 99);
    if (pick < 35) begin
      queue_request(OP_TICK, handle, delay, period, slot);
    end else if (pick < 60) begin
      if ($urandom_range(0, 99) < 70) delay = 16'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 30) period = '0;
      else if (pick < 80) period = 16'($urandom_range(1, 4));
      queue_request(OP_ADD, handle, delay, period, slot);
    end else if (pick < 80) begin
      queue_request(OP_DEL, handle, delay, period, slot);
    end else begin
      queue_request(OP_DISPATCH, handle, delay, period, slot);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start  <= 1'b0;
      in_req <= '0;
    end else begin
      if (start && !busy) predict_request(in_req);
      if (!start || !busy) begin
        if (pending_requests.size() != 0 &&
            ((issued_count >= 80 && issued_count < 160) || $urandom_range(0, 99) >= 27)) begin
          in_req <= pending_requests.pop_front();
          start  <= 1'b1;
          issued_count++;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_res_t want;
    if (rst_n) begin
      if (out_valid !== 1'b0 && out_valid !== 1'b1) begin
        report_mismatch("out_valid is unknown");
      end else if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d slot=%0d handle=%0d last=%0d",
                                    out_res.kind, out_res.slot_index, out_res.run_handle,
                                    out_res.last));
        end else begin
          want = expected_results.pop_front();
          if (out_res.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", out_res.kind, want.kind));
          if (out_res.slot_index !== want.slot_index)
            report_mismatch($sformatf("slot_index %0d, want %0d",
                                      out_res.slot_index, want.slot_index));
          if (out_res.run_handle !== want.run_handle)
            report_mismatch($sformatf("run_handle %0d, want %0d",
                                      out_res.run_handle, want.run_handle));
          if (out_res.last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", out_res.last, want.last));
        end
      end
    end
  end

  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_state[s]  = SLOT_EMPTY;
      slot_handle[s] = '0;
      slot_delay[s]  = '0;
      slot_period[s] = '0;
      slot_runs[s]   = '0;
    end

    queue_request(OP_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
    queue_request(OP_DISPATCH, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
    queue_request(OP_DEL, 8'h00, 16'h0000, 16'h0000, 3'd0);
    queue_request(OP_ADD, 8'hFF, 16'h0000, 16'h0000, 3'd0);
    queue_request(OP_ADD, 8'h00, 16'hFFFF, 16'hFFFF, 3'd7);
    queue_request(OP_ADD, 8'hA5, 16'h0001, 16'h0002, 3'd0);
    queue_request(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd7);
    queue_request(OP_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
    queue_request(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);
    queue_request(OP_DEL, 8'h00, 16'h0000, 16'h0000, 3'd1);
    queue_request(OP_DEL, 8'hFF, 16'hFFFF, 16'hFFFF, 3'd1);
    queue_request(OP_ADD, 8'h11, 16'h0000, 16'h0001, 3'd0);
    queue_request(OP_ADD, 8'h22, 16'h0000, 16'h0000, 3'd0);
    queue_request(OP_ADD, 8'h33, 16'h0001, 16'h0000, 3'd0);
    queue_request(OP_ADD, 8'h44, 16'h0000, 16'hFFFF, 3'd0);
    queue_request(OP_ADD, 8'h55, 16'h0002, 16'h0001, 3'd0);
    queue_request(OP_ADD, 8'h66, 16'h0000, 16'h0003, 3'd0);
    queue_request(OP_ADD, 8'h77, 16'h0000, 16'h0000, 3'd0);
    queue_request(OP_ADD, 8'h88, 16'h0000, 16'h0000, 3'd0);
    queue_request(OP_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
    queue_request(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);
    queue_request(OP_DEL, 8'h00, 16'h0000, 16'h0000, 3'd7);
    queue_request(OP_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
    queue_request(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);

    repeat (196) queue_random_request();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_requests.size() != 0 || start || expected_results.size() != 0);
    repeat (NUM_SLOTS + 8) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/csched_pkg.sv
sv/csched_datapath.sv
sv/csched_ctrl.sv
sv/cooperative_task_scheduler_core.sv
test/cooperative_task_scheduler_core_tb.sv
